// ----- rtl/tga_rle_pixel_decoder_macros.svh -----
// assertion helpers used by the decoder
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TGA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tga_rle_pkg.sv -----
package tga_rle_pkg;

    typedef enum logic [1:0] {
        ST_TOTAL,
        ST_IDLE,
        ST_ADV
    } state_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_TRUNC    = 2'd2
    } err_t;

    localparam logic [2:0] CFG_RLE_MODE    = 3'd0;
    localparam logic [2:0] CFG_BPP         = 3'd1;
    localparam logic [2:0] CFG_WIDTH       = 3'd2;
    localparam logic [2:0] CFG_HEIGHT      = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_TOP  = 3'd4;
    localparam logic [2:0] CFG_COLOR_KEY   = 3'd5;

    localparam logic [7:0]  COUNT_MASK = 8'h7F;
    localparam logic [7:0]  RUN_FLAG   = 8'h80;
    localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;
    localparam logic [7:0]  OPAQUE     = 8'd255;

    localparam int COL_W = 17;

    // result of one wrap step of the column counter
    typedef struct packed {
        logic             ge;
        logic [COL_W-1:0] diff;
    } step_t;

endpackage

// ----- rtl/tga_rle_step.sv -----
module tga_rle_step (
    input  logic [tga_rle_pkg::COL_W-1:0] col,
    input  logic [15:0]                   width,
    output tga_rle_pkg::step_t            res
);
    import tga_rle_pkg::*;

    logic [COL_W-1:0] width_ext;

    assign width_ext = {{(COL_W-16){1'b0}}, width};

    // shared compare and subtract used once per wrapped row
    always_comb
    begin
        res.ge   = (col >= width_ext);
        res.diff = col - width_ext;
    end

endmodule

// ----- rtl/tga_rle_pixel_decoder.sv -----
// tga_rle_pixel_decoder: decodes the pixel-data section of a truecolour image,
// raw or run-length packed, into pixel/run descriptors.
// input stream (s_*): one data byte per transaction, s_tlast marks the last byte
// available. output stream (m_*): one descriptor per completed pixel or run,
// m_tlast set when it completes the image, m_tuser carries the error code.
// cfg_*: register writes (index, data); every valid index restarts decoding.
// flow: a header byte or a non-final pixel byte is handled in the idle state. a
// byte that completes a pixel, unless it ends the image or the stream, moves the
// block to a wrap state for the row wraps the run causes (up to 128 with a
// one-pixel-wide image), wrapped one row per cycle through a single
// compare/subtract unit while s_tready is low. the descriptor is registered in
// the output register, or in the skid register when the receiver stalls. after
// a register write or reset the block forms width*height before taking bytes.
// when the receiver stalls, one extra descriptor is parked in a skid register;
// with that register full, s_tready stays low until the output drains.
// reset restores the control registers' defaults and empties the output.
// after image completion or an error, bytes are accepted and dropped.
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // pixel, dest_row, start_col, run_length
    output logic        m_tlast,    // image_done
    output logic [1:0]  m_tuser,    // error_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tga_rle_pkg::*;

    state_t           state_reg, state_next;
    logic             rle_mode_reg, rle_mode_next;
    logic [2:0]       bpp_reg, bpp_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      height_reg, height_next;
    logic             origin_top_reg, origin_top_next;
    logic [31:0]      color_key_reg, color_key_next;
    logic [31:0]      total_reg, total_next;
    logic             expect_hdr_reg, expect_hdr_next;
    logic             is_run_reg, is_run_next;
    logic [7:0]       left_reg, left_next;
    logic [1:0]       byte_idx_reg, byte_idx_next;
    logic [23:0]      pix_bytes_reg, pix_bytes_next;
    logic [31:0]      decoded_reg, decoded_next;
    logic [15:0]      row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             finished_reg, finished_next;
    logic             failed_reg, failed_next;

    logic             out_valid_reg, out_valid_next;
    logic [71:0]      out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic [1:0]       out_user_reg, out_user_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [71:0]      pend_data_reg, pend_data_next;
    logic             pend_last_reg, pend_last_next;
    logic [1:0]       pend_user_reg, pend_user_next;

    logic             res_valid;
    logic [71:0]      res_data;
    logic             res_last;
    logic [1:0]       res_user;

    logic [15:0]      w_eff, h_eff;
    logic             in_hit;
    logic [7:0]       count;
    logic [32:0]      hdr_sum;
    logic [31:0]      pix;
    logic [7:0]       len;
    logic [15:0]      dest_row;
    logic             done;
    step_t            step;

    assign w_eff = (width_reg == 16'd0) ? 16'd1 : width_reg;
    assign h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;

    assign s_tready  = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_user_reg;

    assign in_hit = s_tvalid && s_tready;

    tga_rle_step u_step (
        .col   (col_reg),
        .width (w_eff),
        .res   (step)
    );

    always_comb
    begin
        state_next      = state_reg;
        rle_mode_next   = rle_mode_reg;
        bpp_next        = bpp_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        origin_top_next = origin_top_reg;
        color_key_next  = color_key_reg;
        total_next      = total_reg;
        expect_hdr_next = expect_hdr_reg;
        is_run_next     = is_run_reg;
        left_next       = left_reg;
        byte_idx_next   = byte_idx_reg;
        pix_bytes_next  = pix_bytes_reg;
        decoded_next    = decoded_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        finished_next   = finished_reg;
        failed_next     = failed_reg;

        res_valid = 1'b0;
        res_data  = '0;
        res_last  = 1'b0;
        res_user  = ERR_NONE;

        count   = (s_tdata & COUNT_MASK) + 8'd1;
        hdr_sum = {1'b0, decoded_reg} + {25'd0, count};
        len     = 8'd1;
        done    = 1'b0;

        if (bpp_reg == 3'd3)
        begin
            pix = {OPAQUE, s_tdata, pix_bytes_reg[15:0]};
        end
        else
        begin
            pix = {s_tdata, pix_bytes_reg};
        end
        if ((color_key_reg != 32'd0) && ((pix & RGB_MASK) == (color_key_reg & RGB_MASK)))
        begin
            pix = pix & RGB_MASK;
        end
        dest_row = origin_top_reg ? row_reg : (h_eff - 16'd1 - row_reg);

        unique case (state_reg)
            ST_TOTAL:
            begin
                total_next = {16'd0, w_eff} * {16'd0, h_eff};
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_hit && !finished_reg && !failed_reg)
                begin
                    if (rle_mode_reg && expect_hdr_reg)
                    begin
                        if (hdr_sum > {1'b0, total_reg})
                        begin
                            failed_next = 1'b1;
                            res_valid   = 1'b1;
                            res_user    = ERR_OVERFLOW;
                        end
                        else
                        begin
                            is_run_next     = (s_tdata & RUN_FLAG) != 8'd0;
                            left_next       = count;
                            expect_hdr_next = 1'b0;
                            if (s_tlast)
                            begin
                                failed_next = 1'b1;
                                res_valid   = 1'b1;
                                res_user    = ERR_TRUNC;
                            end
                        end
                    end
                    else if ({1'b0, byte_idx_reg} + 3'd1 < ((bpp_reg == 3'd3) ? 3'd3 : 3'd4))
                    begin
                        case (byte_idx_reg)
                            2'd0:    pix_bytes_next[7:0]   = s_tdata;
                            2'd1:    pix_bytes_next[15:8]  = s_tdata;
                            2'd2:    pix_bytes_next[23:16] = s_tdata;
                            default: pix_bytes_next        = pix_bytes_reg;
                        endcase
                        byte_idx_next = byte_idx_reg + 2'd1;
                        if (s_tlast)
                        begin
                            failed_next = 1'b1;
                            res_valid   = 1'b1;
                            res_user    = ERR_TRUNC;
                        end
                    end
                    else
                    begin
                        byte_idx_next  = 2'd0;
                        pix_bytes_next = 24'd0;
                        if (rle_mode_reg)
                        begin
                            if (is_run_reg)
                            begin
                                len       = left_reg;
                                left_next = 8'd0;
                            end
                            else
                            begin
                                left_next = left_reg - 8'd1;
                            end
                            if (left_next == 8'd0)
                            begin
                                expect_hdr_next = 1'b1;
                            end
                        end
                        decoded_next = decoded_reg + {24'd0, len};
                        done         = decoded_next >= total_reg;
                        res_valid    = 1'b1;
                        res_data     = {len, col_reg[15:0], dest_row, pix};
                        res_last     = done;
                        if (done)
                        begin
                            finished_next = 1'b1;
                        end
                        else if (s_tlast)
                        begin
                            failed_next = 1'b1;
                            res_user    = ERR_TRUNC;
                        end
                        else
                        begin
                            // position moves on, then wraps one row per cycle
                            col_next   = col_reg + {{(COL_W-8){1'b0}}, len};
                            state_next = ST_ADV;
                        end
                    end
                end
            end
            ST_ADV:
            begin
                if (step.ge)
                begin
                    col_next = step.diff;
                    row_next = row_reg + 16'd1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_TOTAL;
            end
        endcase

        if (cfg_valid && cfg_ready && (cfg_index <= CFG_COLOR_KEY))
        begin
            unique case (cfg_index)
                CFG_RLE_MODE:   rle_mode_next   = cfg_data[0];
                CFG_BPP:        bpp_next        = cfg_data[2:0];
                CFG_WIDTH:      width_next      = cfg_data[15:0];
                CFG_HEIGHT:     height_next     = cfg_data[15:0];
                CFG_ORIGIN_TOP: origin_top_next = cfg_data[0];
                default:        color_key_next  = cfg_data;
            endcase
            state_next      = ST_TOTAL;
            expect_hdr_next = rle_mode_next;
            is_run_next     = 1'b0;
            left_next       = 8'd0;
            byte_idx_next   = 2'd0;
            pix_bytes_next  = 24'd0;
            decoded_next    = 32'd0;
            row_next        = 16'd0;
            col_next        = '0;
            finished_next   = 1'b0;
            failed_next     = 1'b0;
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_user_next   = out_user_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_last_next  = pend_last_reg;
        pend_user_next  = pend_user_reg;

        if (!out_valid_reg || m_tready)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = pend_data_reg;
                out_last_next   = pend_last_reg;
                out_user_next   = pend_user_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
                out_last_next  = res_last;
                out_user_next  = res_user;
            end
        end
        else if (res_valid)
        begin
            pend_valid_next = 1'b1;
            pend_data_next  = res_data;
            pend_last_next  = res_last;
            pend_user_next  = res_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_TOTAL;
            rle_mode_reg   <= 1'b1;
            bpp_reg        <= 3'd4;
            width_reg      <= 16'd1;
            height_reg     <= 16'd1;
            origin_top_reg <= 1'b0;
            color_key_reg  <= 32'd0;
            total_reg      <= 32'd1;
            expect_hdr_reg <= 1'b1;
            is_run_reg     <= 1'b0;
            left_reg       <= 8'd0;
            byte_idx_reg   <= 2'd0;
            pix_bytes_reg  <= 24'd0;
            decoded_reg    <= 32'd0;
            row_reg        <= 16'd0;
            col_reg        <= '0;
            finished_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rle_mode_reg   <= rle_mode_next;
            bpp_reg        <= bpp_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            origin_top_reg <= origin_top_next;
            color_key_reg  <= color_key_next;
            total_reg      <= total_next;
            expect_hdr_reg <= expect_hdr_next;
            is_run_reg     <= is_run_next;
            left_reg       <= left_next;
            byte_idx_reg   <= byte_idx_next;
            pix_bytes_reg  <= pix_bytes_next;
            decoded_reg    <= decoded_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            finished_reg   <= finished_next;
            failed_reg     <= failed_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_user_reg  <= out_user_next;
        pend_data_reg <= pend_data_next;
        pend_last_reg <= pend_last_next;
        pend_user_reg <= pend_user_next;
    end

    `TGA_ASSERT_NOW(a_skid_behind_out, clk, rst_n, pend_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `TGA_ASSERT_NEXT(a_wrap_shrinks_col, clk, rst_n, (state_reg == ST_ADV) && step.ge,
        col_reg < $past(col_reg), "row wrap did not reduce the column")
    `TGA_ASSERT_NOW(a_overflow_blank, clk, rst_n, m_tvalid && (m_tuser == ERR_OVERFLOW),
        (m_tdata == 72'd0) && !m_tlast, "overflow descriptor carries data")
    `TGA_ASSERT_NOW(a_ok_has_length, clk, rst_n, m_tvalid && (m_tuser == ERR_NONE),
        m_tdata[71:64] != 8'd0, "good descriptor with zero run length")
    `TGA_ASSERT_NEXT(a_quiet_when_stopped, clk, rst_n,
        (finished_reg || failed_reg) && !pend_valid_reg && !out_valid_reg,
        !m_tvalid, "descriptor produced after finish or failure")

endmodule
